### rtl/core/triangle_min_path_sum_unit_defines.svh
// ----------------------------------------------------------------------------
// Triangle minimum path sum unit: assertion macros
// Shared assertion wrappers, compiled out when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef TRIANGLE_MIN_PATH_SUM_UNIT_DEFINES_SVH
`define TRIANGLE_MIN_PATH_SUM_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define TMPS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("triangle_min_path_sum_unit: assertion failed");
`define TMPS_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("triangle_min_path_sum_unit: assertion failed");
`else
`define TMPS_ASSERT(lbl, prop)
`define TMPS_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

### rtl/core/tmps_pkg.sv
// ----------------------------------------------------------------------------
// Triangle minimum path sum package
// Sizes, limits and the saturating adder of the path sum datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tmps_pkg;

  localparam int MAX_ROWS = 256;
  localparam int ROW_W    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int VAL_W    = 16;
  localparam int SUM_W    = 32;

  localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};
  localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(MAX_ROWS - 1);

  function automatic logic signed [SUM_W-1:0] sat_add(
    input logic signed [SUM_W-1:0] a,
    input logic signed [SUM_W-1:0] b
  );
    logic signed [SUM_W:0] s;
    s = {a[SUM_W-1], a} + {b[SUM_W-1], b};
    if (s[SUM_W] != s[SUM_W-1]) begin
      return s[SUM_W] ? SUM_MIN : SUM_MAX;
    end
    return s[SUM_W-1:0];
  endfunction

endpackage

### rtl/core/triangle_min_path_sum_unit.sv
// ----------------------------------------------------------------------------
// Triangle minimum path sum unit
// Streams a number triangle row by row and reports the minimum path sum.
// ----------------------------------------------------------------------------
// The unit accepts one triangle entry per clock cycle while s_axis_tready is
// high, with no gaps needed between entries or triangles. Each entry first
// reads the best sum of its column from the row store, a simple dual-port
// memory, then adds the smaller upper neighbor, writes the new sum back and
// updates the running minimum. When two consecutive entries use the same
// column, the newer sum is forwarded past the store. The result of a
// final-row entry that ends its row enters the output register as that
// entry completes. While a result waits there, entries that produce no result
// keep flowing; the input stalls only when a second result is ready before
// the first has been taken. The store needs no clearing pass after reset.
`timescale 1ns / 1ps

`include "triangle_min_path_sum_unit_defines.svh"

module triangle_min_path_sum_unit
  import tmps_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    s_axis_tvalid,
  output logic                    s_axis_tready,
  input  logic [VAL_W-1:0]        s_axis_tdata,   // value
  input  logic [1:0]              s_axis_tuser,   // start_req, final_row
  output logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  output logic [SUM_W-1:0]        m_axis_tdata    // min_sum
);

  logic signed [SUM_W-1:0] row_sums [MAX_ROWS];
  logic signed [SUM_W-1:0] rdata;

  logic [ROW_W-1:0] row_index, row_index_next;
  logic [ROW_W-1:0] column_index, column_index_next;
  logic [ROW_W-1:0] cur_row, cur_col;
  logic             accept;

  logic                    s1_valid;
  logic signed [VAL_W-1:0] s1_value;
  logic                    s1_start, s1_final, s1_apex, s1_first, s1_last;
  logic [ROW_W-1:0]        s1_addr;
  logic                    s1_fwd;
  logic signed [SUM_W-1:0] s1_fwd_data;
  logic                    s1_fire, s1_emit;

  logic signed [SUM_W-1:0] old_sum, left_eff, upper, sum, rm_eff, rm_new;
  logic signed [SUM_W-1:0] left_upper_sum, running_min;
  logic signed [SUM_W-1:0] out_data;
  logic                    out_valid;

  assign s1_fire       = s1_valid && (!s1_emit || !out_valid || m_axis_tready);
  assign s_axis_tready = !s1_valid || s1_fire;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    cur_row = s_axis_tuser[0] ? '0 : row_index;
    cur_col = s_axis_tuser[0] ? '0 : column_index;
    if (cur_col == cur_row) begin
      row_index_next    = (cur_row == LAST_ROW) ? cur_row : cur_row + 1'b1;
      column_index_next = '0;
    end else begin
      row_index_next    = cur_row;
      column_index_next = cur_col + 1'b1;
    end
  end

  always_comb begin
    old_sum  = s1_fwd ? s1_fwd_data : rdata;
    left_eff = s1_start ? '0 : left_upper_sum;
    if (s1_first) begin
      upper = old_sum;
    end else if (s1_last) begin
      upper = left_eff;
    end else begin
      upper = (left_eff < old_sum) ? left_eff : old_sum;
    end
    if (s1_apex) begin
      sum = SUM_W'(s1_value);
    end else begin
      sum = sat_add(SUM_W'(s1_value), upper);
    end
    rm_eff = s1_start ? SUM_MAX : running_min;
    rm_new = (s1_final && (sum < rm_eff)) ? sum : rm_eff;
    s1_emit = s1_last && s1_final;
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      row_sums[s1_addr] <= sum;
    end
    if (accept) begin
      rdata <= row_sums[cur_col];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_index      <= '0;
      column_index   <= '0;
      s1_valid       <= 1'b0;
      out_valid      <= 1'b0;
      left_upper_sum <= '0;
      running_min    <= SUM_MAX;
    end else begin
      if (accept) begin
        row_index    <= row_index_next;
        column_index <= column_index_next;
        s1_valid     <= 1'b1;
      end else if (s1_fire) begin
        s1_valid <= 1'b0;
      end
      if (s1_fire) begin
        left_upper_sum <= old_sum;
        running_min    <= s1_emit ? SUM_MAX : rm_new;
      end
      if (s1_fire && s1_emit) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_value    <= s_axis_tdata;
      s1_start    <= s_axis_tuser[0];
      s1_final    <= s_axis_tuser[1];
      s1_apex     <= (cur_row == '0);
      s1_first    <= (cur_col == '0);
      s1_last     <= (cur_col == cur_row);
      s1_addr     <= cur_col;
      s1_fwd      <= s1_valid && (s1_addr == cur_col);
      s1_fwd_data <= sum;
    end
    if (s1_fire && s1_emit) begin
      out_data <= rm_new;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

  `TMPS_ASSERT(a_col_within_row, column_index <= row_index)
  `TMPS_ASSERT(a_min_rearms, (s1_fire && s1_emit) |=> (running_min == SUM_MAX))
  `TMPS_ASSERT(a_same_col_forwarded,
    (accept && s1_valid && (s1_addr == cur_col)) |=> s1_fwd)
  `TMPS_ASSERT(a_stall_only_on_full_output,
    !s_axis_tready |-> (s1_valid && m_axis_tvalid && !m_axis_tready))
  `TMPS_ASSERT_ALWAYS(a_reset_clears, rst |=> (!s1_valid && !m_axis_tvalid))

endmodule

### tb/sv/triangle_min_path_sum_unit_tb.sv
// ----------------------------------------------------------------------------
// Triangle minimum path sum unit testbench
// Streams number triangles into the unit and compares every reported minimum
// path sum with the value that a behavioral path sum tracker in this file
// predicts. Covers directed corner cases, random traffic under several idle
// and stall patterns and a long output hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module triangle_min_path_sum_unit_tb;
  import tmps_pkg::*;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [VAL_W-1:0] s_axis_tdata = '0;   // value
  logic [1:0]       s_axis_tuser = '0;   // start_req, final_row
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [SUM_W-1:0] m_axis_tdata;        // min_sum

  int src_idle_pct = 0;
  int snk_stall_pct = 0;
  int hold_left = 0;
  int hold_req = 0;
  int hold_done = 0;
  int fail_count = 0;
  int entries_sent = 0;

  logic signed [SUM_W-1:0] min_sum_q[$];

  // Path sum tracker state.
  logic signed [SUM_W-1:0] path_sum [MAX_ROWS];
  int unsigned             tri_row = 0;
  int unsigned             tri_col = 0;
  logic signed [SUM_W-1:0] left_upper = '0;
  logic signed [SUM_W-1:0] best_final = SUM_MAX;

  triangle_min_path_sum_unit uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic logic signed [SUM_W-1:0] clamp_add(
    input logic signed [SUM_W-1:0] a,
    input logic signed [SUM_W-1:0] b
  );
    longint s;
    s = longint'(a) + longint'(b);
    if (s > longint'(SUM_MAX)) return SUM_MAX;
    if (s < longint'(SUM_MIN)) return SUM_MIN;
    return s[SUM_W-1:0];
  endfunction

  function automatic void track_entry(
    input logic signed [VAL_W-1:0] v,
    input bit                      st,
    input bit                      fin
  );
    logic signed [SUM_W-1:0] old_sum;
    logic signed [SUM_W-1:0] upper;
    logic signed [SUM_W-1:0] sum;
    if (st) begin
      tri_row = 0;
      tri_col = 0;
      left_upper = '0;
      best_final = SUM_MAX;
    end
    old_sum = path_sum[tri_col];
    if (tri_row == 0) begin
      sum = SUM_W'(v);
    end else begin
      if (tri_col == 0) upper = old_sum;
      else if (tri_col == tri_row) upper = left_upper;
      else upper = (left_upper < old_sum) ? left_upper : old_sum;
      sum = clamp_add(SUM_W'(v), upper);
    end
    left_upper = old_sum;
    path_sum[tri_col] = sum;
    if (fin && sum < best_final) best_final = sum;
    if (tri_col == tri_row) begin
      if (fin) begin
        min_sum_q.insert(min_sum_q.size(), best_final);
        best_final = SUM_MAX;
      end
      if (tri_row + 1 < MAX_ROWS) tri_row = tri_row + 1;
      tri_col = 0;
    end else begin
      tri_col = tri_col + 1;
    end
  endfunction

  function automatic logic signed [VAL_W-1:0] pick_value();
    case ($urandom_range(9))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return VAL_W'($signed($urandom_range(16)) - 8);
      default: return VAL_W'($urandom);
    endcase
  endfunction

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_entry(
    input logic signed [VAL_W-1:0] v,
    input bit                      st,
    input bit                      fin
  );
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= v;
    s_axis_tuser  <= {fin, st};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    track_entry(v, st, fin);
    entries_sent++;
    @(negedge clk);
  endtask

  // Sends the first count entries of a triangle with the given number of rows.
  task automatic send_triangle(input int rows, input int count);
    int n;
    n = 0;
    for (int r = 0; r < rows; r++) begin
      for (int c = 0; c <= r; c++) begin
        if (n < count) send_entry(pick_value(), n == 0, r == rows - 1);
        n++;
      end
    end
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (min_sum_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    @(negedge clk);
  endtask

  always @(negedge clk) begin
    if (hold_req != hold_done) begin
      hold_done <= hold_req;
      hold_left <= 300;
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= snk_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (min_sum_q.size() == 0) begin
        $error("unexpected min_sum transfer: actual %0d", $signed(m_axis_tdata));
        fail_count++;
      end else begin
        if (m_axis_tdata !== min_sum_q[0]) begin
          $error("min_sum mismatch: expected %0d, actual %0d",
                 min_sum_q[0], $signed(m_axis_tdata));
          fail_count++;
        end
        void'(min_sum_q.pop_front());
      end
    end
  end

  task automatic test_directed();
    src_idle_pct = 0;
    snk_stall_pct = 0;
    // First entry after reset without a start request acts as the apex.
    send_entry(16'sh8000, 1'b0, 1'b1);
    // Extreme values over three rows.
    send_entry(16'sh7FFF, 1'b1, 1'b0);
    send_entry(16'sh8000, 1'b0, 1'b0);
    send_entry(16'sh7FFF, 1'b0, 1'b0);
    send_entry(-16'sd1, 1'b0, 1'b1);
    send_entry(16'sd0, 1'b0, 1'b1);
    send_entry(16'sh8000, 1'b0, 1'b1);
    // Mixed flags: an unflagged row end emits nothing, the minimum carries on.
    send_entry(16'sd7, 1'b1, 1'b0);
    send_entry(16'sd3, 1'b0, 1'b1);
    send_entry(-16'sd4, 1'b0, 1'b0);
    send_entry(16'sd1, 1'b0, 1'b0);
    send_entry(16'sd2, 1'b0, 1'b1);
    send_entry(-16'sd5, 1'b0, 1'b1);
    // A start request in the middle of a row.
    send_entry(16'sd100, 1'b1, 1'b0);
    send_entry(16'sd1, 1'b0, 1'b0);
    send_entry(-16'sd2, 1'b1, 1'b1);
    // The triangle keeps growing after a final row.
    send_entry(16'sd9, 1'b1, 1'b1);
    send_entry(-16'sd1, 1'b0, 1'b1);
    send_entry(16'sd1, 1'b0, 1'b1);
    drain();
  endtask

  task automatic test_random_traffic(
    input int src_pct,
    input int snk_pct,
    input int n_entries
  );
    int e0;
    int kind;
    int rows;
    src_idle_pct = src_pct;
    snk_stall_pct = snk_pct;
    e0 = entries_sent;
    while (entries_sent - e0 < n_entries) begin
      kind = $urandom_range(99);
      rows = ($urandom_range(9) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 6);
      if (kind < 75) begin
        send_triangle(rows, rows * (rows + 1) / 2);
      end else if (kind < 88) begin
        send_triangle(rows, $urandom_range(1, rows * (rows + 1) / 2));
      end else begin
        repeat ($urandom_range(1, 6))
          send_entry(pick_value(), $urandom_range(7) == 0, $urandom_range(2) == 0);
      end
    end
    drain();
  endtask

  task automatic test_backpressure();
    src_idle_pct = 0;
    snk_stall_pct = 0;
    @(posedge clk);
    hold_req++;
    @(negedge clk);
    repeat (60) send_entry(pick_value(), 1'b1, 1'b1);
    drain();
  endtask

  initial begin
    foreach (path_sum[k]) path_sum[k] = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_random_traffic(0, 0, 70);
    test_random_traffic(62, 0, 70);
    test_random_traffic(0, 62, 70);
    test_random_traffic(29, 29, 70);
    test_backpressure();
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Some tests failed");
    $finish;
  end

endmodule
